### design/pdf_pkg.sv
// ---------------------------------------------------------------------------
// pdf_pkg: shared types and constants of the package deframer
// Region and status codes, header constants and the per-byte result record.
// ---------------------------------------------------------------------------
`default_nettype none

package pdf_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned REGION_W = 3;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned KLEN_W   = 16;
    localparam int unsigned CLEN_W   = 32;
    localparam int unsigned COUNT_W  = 32;

    typedef logic [REGION_W-1:0] region_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam region_t REG_HEADER = 3'd0;
    localparam region_t REG_KLEN   = 3'd1;
    localparam region_t REG_KEY    = 3'd2;
    localparam region_t REG_IV     = 3'd3;
    localparam region_t REG_MAC    = 3'd4;
    localparam region_t REG_CLEN   = 3'd5;
    localparam region_t REG_DATA   = 3'd6;

    localparam status_t ST_BUSY    = 3'd0;
    localparam status_t ST_OK      = 3'd1;
    localparam status_t ST_MAGIC   = 3'd2;
    localparam status_t ST_VERSION = 3'd3;
    localparam status_t ST_TRUNC   = 3'd4;
    localparam status_t ST_LENGTH  = 3'd5;
    localparam status_t ST_ALIGN   = 3'd6;

    localparam logic [BYTE_W-1:0] VERSION_BYTE = 8'h01;

    // One result per accepted byte.
    typedef struct packed {
        logic [CLEN_W-1:0] cipher_length;
        logic [KLEN_W-1:0] key_length;
        status_t           status;
        region_t           region;
        logic [BYTE_W-1:0] out_byte;
    } pdf_result_t;

    // Expected magic "ASCE", one byte per header position.
    function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] val;
        unique case (idx)
            2'd0:    val = 8'h41;
            2'd1:    val = 8'h53;
            2'd2:    val = 8'h43;
            default: val = 8'h45;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### design/pdf_parse.sv
// ---------------------------------------------------------------------------
// pdf_parse: front end of the package deframer
// Tracks the package layout byte by byte, latches the first error and builds
// the tagged result for each accepted byte.
// ---------------------------------------------------------------------------
`default_nettype none

module pdf_parse (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      accept,
    input  wire  [7:0]               in_byte,
    input  wire                      is_last,
    output pdf_pkg::pdf_result_t     result
);
    import pdf_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_KLEN   = 3'd1,
        PH_KEY    = 3'd2,
        PH_IV     = 3'd3,
        PH_MAC    = 3'd4,
        PH_CLEN   = 3'd5,
        PH_DATA   = 3'd6
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [COUNT_W-1:0]   count_reg, count_next, count_inc;
    logic [KLEN_W-1:0]    klen_reg, klen_next;
    logic [CLEN_W-1:0]    clen_reg, clen_next;
    status_t              err_reg, err_next;
    logic                 len_eq;
    status_t              status;

    assign count_inc = count_reg + 32'd1;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        klen_next  = klen_reg;
        clen_next  = clen_reg;
        err_next   = err_reg;
        len_eq     = 1'b0;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (count_reg < 32'd4)
                begin
                    if (in_byte != magic_byte(count_reg[1:0]) && err_reg == ST_BUSY)
                        err_next = ST_MAGIC;
                end
                else if (count_reg == 32'd4)
                begin
                    if (in_byte != VERSION_BYTE && err_reg == ST_BUSY)
                        err_next = ST_VERSION;
                end
                count_next = count_inc;
                if (count_reg == 32'd7)
                begin
                    phase_next = PH_KLEN;
                    count_next = '0;
                end
            end
            PH_KLEN:
            begin
                klen_next  = {klen_reg[7:0], in_byte};
                count_next = count_inc;
                if (count_reg == 32'd1)
                begin
                    phase_next = (klen_next == '0) ? PH_IV : PH_KEY;
                    count_next = '0;
                end
            end
            PH_KEY:
            begin
                count_next = count_inc;
                if (count_inc >= {16'd0, klen_reg})
                begin
                    phase_next = PH_IV;
                    count_next = '0;
                end
            end
            PH_IV:
            begin
                count_next = count_inc;
                if (count_reg == 32'd15)
                begin
                    phase_next = PH_MAC;
                    count_next = '0;
                end
            end
            PH_MAC:
            begin
                count_next = count_inc;
                if (count_reg == 32'd31)
                begin
                    phase_next = PH_CLEN;
                    count_next = '0;
                end
            end
            PH_CLEN:
            begin
                clen_next  = {clen_reg[23:0], in_byte};
                count_next = count_inc;
                if (count_reg == 32'd3)
                begin
                    phase_next = PH_DATA;
                    count_next = '0;
                    len_eq     = (clen_next == '0);
                end
            end
            PH_DATA:
            begin
                // The count never passes the decoded length, so reaching it
                // means every further byte is excess.
                if (count_reg >= clen_reg)
                begin
                    len_eq = 1'b1;
                    if (err_reg == ST_BUSY)
                        err_next = ST_LENGTH;
                end
                else
                begin
                    count_next = count_inc;
                    len_eq     = (count_inc == clen_reg);
                end
            end
            default:
            begin
                phase_next = PH_DATA;
            end
        endcase
    end

    always_comb
    begin
        status = ST_BUSY;
        if (is_last)
        begin
            priority if (phase_next == PH_HEADER)
                status = ST_MAGIC;
            else if (err_next != ST_BUSY)
                status = err_next;
            else if (phase_next != PH_DATA)
                status = ST_TRUNC;
            else if (!len_eq)
                status = ST_LENGTH;
            else if (clen_next[3:0] != 4'd0)
                status = ST_ALIGN;
            else
                status = ST_OK;
        end
    end

    assign result.out_byte      = in_byte;
    assign result.region        = region_t'(phase_reg);
    assign result.status        = status;
    assign result.key_length    = klen_next;
    assign result.cipher_length = clen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            count_reg <= '0;
            klen_reg  <= '0;
            clen_reg  <= '0;
            err_reg   <= ST_BUSY;
        end
        else if (accept)
        begin
            if (is_last)
            begin
                phase_reg <= PH_HEADER;
                count_reg <= '0;
                klen_reg  <= '0;
                clen_reg  <= '0;
                err_reg   <= ST_BUSY;
            end
            else
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                klen_reg  <= klen_next;
                clen_reg  <= clen_next;
                err_reg   <= err_next;
            end
        end
    end

    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_last) |-> (result.status == ST_BUSY))
        else $error("status reported before the final byte");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_last) |=> (phase_reg == PH_HEADER && count_reg == '0
                                 && err_reg == ST_BUSY))
        else $error("parser did not restart after the final byte");

    a_data_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (count_reg <= clen_reg))
        else $error("ciphertext count passed the decoded length");

endmodule

`default_nettype wire

### design/pdf_fifo.sv
// ---------------------------------------------------------------------------
// pdf_fifo: result queue between parser and output stage
// A small first-in first-out buffer of parsed results.
// ---------------------------------------------------------------------------
`default_nettype none

module pdf_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      push,
    input  pdf_pkg::pdf_result_t     push_data,
    output logic                     full,
    input  wire                      pop,
    output pdf_pkg::pdf_result_t     pop_data,
    output logic                     empty
);
    import pdf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    pdf_result_t       entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("transfer into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("read from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

### design/pdf_out.sv
// ---------------------------------------------------------------------------
// pdf_out: output stage of the package deframer
// Registers one result and presents it on the master stream.
// ---------------------------------------------------------------------------
`default_nettype none

module pdf_out (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    input  pdf_pkg::pdf_result_t     in_data,
    output logic                     in_ready,
    output logic                     m_axis_tvalid,
    input  wire                      m_axis_tready,
    output logic [55:0]              m_axis_tdata,
    output logic [5:0]               m_axis_tuser
);
    import pdf_pkg::*;

    logic        valid_reg;
    pdf_result_t data_reg;

    assign in_ready = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= in_data;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {data_reg.cipher_length, data_reg.key_length, data_reg.out_byte};
    assign m_axis_tuser  = {data_reg.status, data_reg.region};

endmodule

`default_nettype wire

### design/package_deframer.sv
// ---------------------------------------------------------------------------
// package_deframer: byte-stream parser for encrypted packages
// Checks the header, splits the package into regions and reports its status.
// ---------------------------------------------------------------------------
// Usage: bytes of a package enter on the slave stream, one per transfer, with
// tlast on the final byte. Every byte leaves on the master stream as one
// transfer carrying the byte, its region, the key and ciphertext lengths
// decoded so far, and a status that is nonzero only on the final byte.
// An error status tells the consumer to drop the payload it already took.
// Throughput is one byte per cycle unless the receiver stalls. Each accepted
// byte's result is written into the queue, then registered in the output
// stage before it shows up on the master stream; the parser runs ahead of
// the output register through a queue of QUEUE_DEPTH results, so the rate is
// set by the output handshake alone. When the receiver stalls, the queue fills
// and s_axis_tready drops once it holds QUEUE_DEPTH results; the master
// outputs hold until taken. Reset empties the queue and returns the parser to
// the start of a package; after each final byte the parser also restarts on its own.
// ---------------------------------------------------------------------------
`default_nettype none

module package_deframer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // in_byte[7:0]
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_byte[7:0], key_length[23:8], cipher_length[55:24]
    output logic [5:0]  m_axis_tuser    // region[2:0], status[5:3]
);
    import pdf_pkg::*;

    pdf_result_t parse_result;
    pdf_result_t queue_data;
    logic        accept;
    logic        queue_full;
    logic        queue_empty;
    logic        out_ready;
    logic        queue_pop;

    assign s_axis_tready = !queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign queue_pop     = !queue_empty && out_ready;

    pdf_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_axis_tdata),
        .is_last (s_axis_tlast),
        .result  (parse_result)
    );

    pdf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (parse_result),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (queue_data),
        .empty     (queue_empty)
    );

    pdf_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (!queue_empty),
        .in_data       (queue_data),
        .in_ready      (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking testbench for package_deframer
// Feeds whole packages one byte per transfer (well-formed ones and ones with
// bad magic, bad version, truncation, short or excess ciphertext, misaligned
// length and random noise) and checks every output transfer against a
// byte-level parse model kept in step with the accepted input.
// ---------------------------------------------------------------------------

module tb;

    import pdf_pkg::*;

    localparam logic [31:0] MAGIC_WORD = 32'h41534345;
    localparam int IV_LEN   = 16;
    localparam int MAC_LEN  = 32;
    localparam int HDR_LEN  = 8;
    localparam int HOLD_AT  = 300;
    localparam int HOLD_LEN = 200;
    localparam int N_ITEMS  = 1050;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } feed_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [5:0]  m_axis_tuser;

    feed_t       byte_feed_q[$];
    pdf_result_t exp_result_q[$];
    logic [7:0]  pkt[$];

    // Parse state of the model.
    region_t     ps_region = REG_HEADER;
    logic [31:0] ps_count = '0;
    logic [15:0] ps_klen = '0;
    logic [31:0] ps_clen = '0;
    status_t     ps_err = ST_BUSY;

    int    bytes_queued = 0;
    int    n_results = 0;
    int    fail_count = 0;
    int    send_gap = 0;
    int    recv_hold = 0;
    bit    send_calm = 1'b0;
    bit    recv_calm = 1'b0;
    feed_t next_byte;
    pdf_result_t want;
    pdf_result_t got;

    package_deframer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Expected output for one accepted byte; advances the parse state.
    function automatic pdf_result_t deframe_byte(input logic [7:0] b, input logic last);
        pdf_result_t r;
        region_t     rg;
        status_t     st;
        int          idx;
        rg = (ps_region > REG_DATA) ? REG_DATA : ps_region;
        st = ST_BUSY;
        case (rg)
            REG_HEADER:
            begin
                if (ps_count < 4)
                begin
                    idx = ps_count;
                    if (b != MAGIC_WORD[8*(3-idx) +: 8] && ps_err == ST_BUSY)
                        ps_err = ST_MAGIC;
                end
                else if (ps_count == 4)
                begin
                    if (b != VERSION_BYTE && ps_err == ST_BUSY)
                        ps_err = ST_VERSION;
                end
                ps_count++;
                if (ps_count >= HDR_LEN)
                begin
                    ps_region = REG_KLEN;
                    ps_count = '0;
                end
            end
            REG_KLEN:
            begin
                ps_klen = {ps_klen[7:0], b};
                ps_count++;
                if (ps_count >= 2)
                begin
                    ps_region = (ps_klen == 16'd0) ? REG_IV : REG_KEY;
                    ps_count = '0;
                end
            end
            REG_KEY:
            begin
                ps_count++;
                if (ps_count >= ps_klen)
                begin
                    ps_region = REG_IV;
                    ps_count = '0;
                end
            end
            REG_IV:
            begin
                ps_count++;
                if (ps_count >= IV_LEN)
                begin
                    ps_region = REG_MAC;
                    ps_count = '0;
                end
            end
            REG_MAC:
            begin
                ps_count++;
                if (ps_count >= MAC_LEN)
                begin
                    ps_region = REG_CLEN;
                    ps_count = '0;
                end
            end
            REG_CLEN:
            begin
                ps_clen = {ps_clen[23:0], b};
                ps_count++;
                if (ps_count >= 4)
                begin
                    ps_region = REG_DATA;
                    ps_count = '0;
                end
            end
            default:
            begin
                // Ciphertext bytes past the decoded length are excess.
                ps_region = REG_DATA;
                if (ps_count >= ps_clen)
                begin
                    if (ps_err == ST_BUSY)
                        ps_err = ST_LENGTH;
                end
                else
                begin
                    ps_count++;
                end
            end
        endcase

        if (last)
        begin
            if (ps_region == REG_HEADER)
                st = ST_MAGIC;
            else if (ps_err != ST_BUSY)
                st = ps_err;
            else if (ps_region < REG_DATA)
                st = ST_TRUNC;
            else if (ps_count != ps_clen)
                st = ST_LENGTH;
            else if (ps_clen[3:0] != 4'd0)
                st = ST_ALIGN;
            else
                st = ST_OK;
        end

        r.out_byte      = b;
        r.region        = rg;
        r.status        = st;
        r.key_length    = ps_klen;
        r.cipher_length = ps_clen;

        if (last)
        begin
            ps_region = REG_HEADER;
            ps_count  = '0;
            ps_klen   = '0;
            ps_clen   = '0;
            ps_err    = ST_BUSY;
        end
        return r;
    endfunction

    function automatic int draw_wait(input bit calm);
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_v, act_v);
        end
    endtask

    task automatic append_byte(input logic [7:0] b);
        pkt.insert(pkt.size(), b);
    endtask

    // Builds a package in pkt with random reserved, key, IV, MAC and data bytes.
    task automatic build_pkg(input logic [15:0] klen_field, input int key_n,
                             input logic [31:0] clen_field, input int data_n);
        pkt.delete();
        for (int i = 0; i < 4; i++)
            append_byte(MAGIC_WORD[8*(3-i) +: 8]);
        append_byte(VERSION_BYTE);
        repeat (3) append_byte(rand_byte());
        append_byte(klen_field[15:8]);
        append_byte(klen_field[7:0]);
        repeat (key_n + IV_LEN + MAC_LEN) append_byte(rand_byte());
        for (int i = 3; i >= 0; i--)
            append_byte(clen_field[8*i +: 8]);
        repeat (data_n) append_byte(rand_byte());
    endtask

    task automatic cut_pkg(input int n);
        while (pkt.size() > n)
            void'(pkt.pop_back());
    endtask

    task automatic queue_pkg();
        feed_t f;
        for (int i = 0; i < pkt.size(); i++)
        begin
            f.data = pkt[i];
            f.last = (i == pkt.size() - 1);
            byte_feed_q.insert(byte_feed_q.size(), f);
        end
        bytes_queued += pkt.size();
    endtask

    task automatic wait_drained();
        while (byte_feed_q.size() != 0 || s_axis_tvalid || exp_result_q.size() != 0)
            @(negedge clk);
    endtask

    // Sender: offers queued bytes, holding each until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                exp_result_q.insert(exp_result_q.size(),
                                    deframe_byte(s_axis_tdata, s_axis_tlast));
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // Stalled: keep the current transfer on the bus.
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (byte_feed_q.size() != 0)
            begin
                next_byte = byte_feed_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_byte.data;
                s_axis_tlast  <= next_byte.last;
                send_gap = draw_wait(send_calm);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each output transfer and stalls at random, once for long.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.out_byte      = m_axis_tdata[7:0];
                got.key_length    = m_axis_tdata[23:8];
                got.cipher_length = m_axis_tdata[55:24];
                got.region        = m_axis_tuser[2:0];
                got.status        = m_axis_tuser[5:3];
                if (exp_result_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected transfer, expected none, actual %0h",
                             $time, got);
                end
                else
                begin
                    want = exp_result_q.pop_front();
                    check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
                    check_field("region", 32'(want.region), 32'(got.region));
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("key_length", 32'(want.key_length),
                                32'(got.key_length));
                    check_field("cipher_length", want.cipher_length, got.cipher_length);
                end
                n_results++;
                recv_hold = (n_results == HOLD_AT) ? HOLD_LEN : draw_wait(recv_calm);
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int cuts[5];
        int kind;
        int klen;
        int clen;
        cuts = '{9, 12, 20, 40, 64};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed packages.
        build_pkg(16'd0, 0, 32'd0, 0);
        queue_pkg();
        build_pkg(16'd3, 3, 32'd16, 16);
        for (int i = 0; i < 3; i++)
            pkt[10 + i] = 8'hFF;
        for (int i = 0; i < 16; i++)
            pkt[pkt.size() - 16 + i] = 8'h00;
        queue_pkg();
        build_pkg(16'd0, 0, 32'd16, 16);
        pkt[2] = 8'h00;
        queue_pkg();
        // Bad magic and bad version together: the first one is reported.
        build_pkg(16'd0, 0, 32'd0, 0);
        pkt[0] = 8'hFF;
        pkt[4] = 8'h02;
        queue_pkg();
        // Bad version followed by excess ciphertext.
        build_pkg(16'd0, 0, 32'd0, 2);
        pkt[4] = 8'h00;
        queue_pkg();
        build_pkg(16'd0, 0, 32'd0, 0);
        cut_pkg(5);
        queue_pkg();
        build_pkg(16'd0, 0, 32'd0, 0);
        cut_pkg(1);
        queue_pkg();
        build_pkg(16'd0, 0, 32'd0, 0);
        cut_pkg(HDR_LEN);
        queue_pkg();
        // Truncation inside key length, key, IV, MAC and cipher length.
        foreach (cuts[i])
        begin
            build_pkg(16'd4, 4, 32'd16, 16);
            cut_pkg(cuts[i]);
            queue_pkg();
        end
        build_pkg(16'hFFFF, 20, 32'd0, 0);
        cut_pkg(30);
        queue_pkg();
        build_pkg(16'd1, 1, 32'hFFFF_FFFF, 16);
        queue_pkg();
        build_pkg(16'd0, 0, 32'd32, 40);
        queue_pkg();
        build_pkg(16'd0, 0, 32'd0, 3);
        queue_pkg();
        build_pkg(16'd0, 0, 32'd5, 5);
        queue_pkg();
        build_pkg(16'd0, 0, 32'd20, 3);
        queue_pkg();

        // The sender pauses here until every result is back.
        wait_drained();

        while (bytes_queued < N_ITEMS)
        begin
            while (byte_feed_q.size() > 64)
                @(negedge clk);
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 11);
            klen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 100)
                                               : $urandom_range(0, 8);
            clen = 16 * $urandom_range(0, 3);
            case (kind)
                5:
                begin
                    build_pkg(16'(klen), klen, 32'(clen), clen);
                    pkt[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
                end
                6:
                begin
                    build_pkg(16'(klen), klen, 32'(clen), clen);
                    pkt[4] ^= 8'($urandom_range(1, 255));
                end
                7:
                begin
                    build_pkg(16'(klen), klen, 32'(clen), clen);
                    cut_pkg($urandom_range(1, pkt.size() - 1));
                end
                8:
                begin
                    if ($urandom_range(0, 1) == 0)
                        build_pkg(16'(klen), klen, $urandom, $urandom_range(0, 20));
                    else
                        build_pkg(16'(klen), klen, 32'(clen + 16),
                                  $urandom_range(0, clen + 15));
                end
                9:  build_pkg(16'(klen), klen, 32'(clen), clen + $urandom_range(1, 5));
                10:
                begin
                    clen = $urandom_range(1, 40);
                    build_pkg(16'(klen), klen, 32'(clen), clen);
                end
                11:
                begin
                    pkt.delete();
                    repeat ($urandom_range(1, 12)) append_byte(rand_byte());
                end
                default: build_pkg(16'(klen), klen, 32'(clen), clen);
            endcase
            queue_pkg();
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && exp_result_q.size() == 0)
            $display("package_deframer test passed");
        else
            $display("package_deframer test failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("package_deframer test failed");
        $finish;
    end

endmodule
